### src/qbp_pkg.sv
// ----------------------------------------------------------------------------
// qbp_pkg: shared constants and types for the quantize bit packer
// Code widths, packing word geometry, register indexes and reset values.
// ----------------------------------------------------------------------------
package qbp_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int ACC_W         = 7;
    localparam int COMB_W        = MAX_CODE_BITS + ACC_W;
    localparam int WORD_W        = ((COMB_W + 7) / 8) * 8;
    localparam int MAX_BYTES     = WORD_W / 8;
    localparam int CNT_W         = $clog2(MAX_BYTES + 1);
    localparam int SH_W          = $clog2(WORD_W + 1);
    localparam int W_W           = $clog2(MAX_CODE_BITS + 1);
    localparam int IDX_W         = 33;

    typedef enum logic [1:0] {
        CFG_MIN_VALUE      = 2'd0,
        CFG_STEP_RECIP     = 2'd1,
        CFG_BITS_PER_VALUE = 2'd2
    } t_cfg_index;

    localparam logic signed [31:0] MIN_VALUE_RESET  = 32'sd0;
    localparam logic        [31:0] STEP_RECIP_RESET = 32'd65536;
    localparam logic        [5:0]  BITS_RESET       = 6'd8;

endpackage

### src/quantize_bit_packer.sv
// ----------------------------------------------------------------------------
// quantize_bit_packer: sample quantizer and MSB-first byte packer
// Subtracts the offset, scales by the reciprocal step, rounds, saturates to
// the code width and packs codes into a byte stream with a final flush.
// ----------------------------------------------------------------------------
// Path: request -> s1 -> s2 -> s3 -> output register -> first byte out.
// Throughput: one request per cycle while each yields at most one byte and
//   the receiver does not stall; a request yielding several bytes holds the
//   output register until all of them are taken, stalling the pipeline.
// Reset: synchronous active low; clears pipeline valids, pending bits and
//   output count, and loads the configuration registers with their defaults.
module quantize_bit_packer
    import qbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sample,
    input  logic               i_last_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);

    // configuration
    logic signed [31:0] r_cfg_min;
    logic        [31:0] r_cfg_step;
    logic        [5:0]  r_cfg_bits;

    // pipeline
    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic signed [31:0] r_s1_sample;
    logic               r_s1_last, r_s2_last, r_s3_last;
    logic        [31:0] r_s2_mag;
    logic        [63:0] r_s3_prod;

    // packing state
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [2:0]         r_pend, n_pend;

    // output register
    logic [WORD_W-1:0]  r_ob_word;
    logic [CNT_W-1:0]   r_ob_cnt;
    logic               r_ob_last;

    logic               ob_free, s3_adv, s3_ready, s2_ready, s1_ready;
    logic               in_acc, out_acc;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [64:0]        rnd_sum;
    logic [IDX_W-1:0]   idx, code_sat;
    logic [IDX_W:0]     top_ext;
    logic [W_W-1:0]     w_eff;
    logic [COMB_W-1:0]  code_ext, combined;
    logic [SH_W-1:0]    tot_bits;
    logic [2:0]         rem;
    logic [WORD_W-1:0]  aligned;
    logic [CNT_W-1:0]   nb;

    assign o_out_valid = (r_ob_cnt != '0);
    assign o_out_byte  = r_ob_word[WORD_W-1 -: 8];
    assign o_out_last  = r_ob_last && (r_ob_cnt == CNT_W'(1));
    assign out_acc     = o_out_valid && !i_out_stall;

    assign ob_free  = (r_ob_cnt == '0) || ((r_ob_cnt == CNT_W'(1)) && !i_out_stall);
    assign s3_adv   = r_s3_vld && ((nb == '0) || ob_free);
    assign s3_ready = !r_s3_vld || s3_adv;
    assign s2_ready = !r_s2_vld || s3_ready;
    assign s1_ready = !r_s1_vld || s2_ready;
    assign o_in_stall = !s1_ready;
    assign in_acc   = i_in_valid && s1_ready;

    // offset removal: non-positive differences map to index 0
    always_comb begin
        diff = {r_s1_sample[31], r_s1_sample} - {r_cfg_min[31], r_cfg_min};
        mag  = (!diff[32] && (diff != '0)) ? diff[31:0] : 32'd0;
    end

    // round, saturate, and splice the code onto the pending bits
    always_comb begin
        if (r_cfg_bits == '0) begin
            w_eff = W_W'(1);
        end else if (int'(r_cfg_bits) > MAX_CODE_BITS) begin
            w_eff = W_W'(MAX_CODE_BITS);
        end else begin
            w_eff = W_W'(r_cfg_bits);
        end

        rnd_sum = {1'b0, r_s3_prod} + 65'h0_8000_0000;
        idx     = rnd_sum[64:32];
        top_ext = ({{IDX_W{1'b0}}, 1'b1} << w_eff) - {{IDX_W{1'b0}}, 1'b1};
        if ((int'(w_eff) < IDX_W) && ({1'b0, idx} > top_ext)) begin
            code_sat = top_ext[IDX_W-1:0];
        end else begin
            code_sat = idx;
        end
        code_ext = COMB_W'(code_sat);

        combined = (COMB_W'(r_acc) << w_eff) | code_ext;
        tot_bits = SH_W'(r_pend) + SH_W'(w_eff);
        rem      = tot_bits[2:0];
        aligned  = WORD_W'(combined) << (SH_W'(WORD_W) - tot_bits);
        nb       = CNT_W'(tot_bits >> 3) + CNT_W'(r_s3_last && (rem != 3'd0));

        if (r_s3_last) begin
            n_acc  = '0;
            n_pend = 3'd0;
        end else begin
            n_acc  = ACC_W'(combined) & ACC_W'((8'd1 << rem) - 8'd1);
            n_pend = rem;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min  <= MIN_VALUE_RESET;
            r_cfg_step <= STEP_RECIP_RESET;
            r_cfg_bits <= BITS_RESET;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_acc      <= '0;
            r_pend     <= 3'd0;
            r_ob_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_VALUE:      r_cfg_min  <= i_cfg_data;
                    CFG_STEP_RECIP:     r_cfg_step <= i_cfg_data;
                    CFG_BITS_PER_VALUE: r_cfg_bits <= i_cfg_data[5:0];
                    default:            ;
                endcase
            end
            if (s1_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_ready) begin
                r_s3_vld <= r_s2_vld;
            end
            if (s3_adv) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
            end
            if (s3_adv && (nb != '0)) begin
                r_ob_cnt <= nb;
            end else if (out_acc) begin
                r_ob_cnt <= r_ob_cnt - CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_sample;
            r_s1_last   <= i_last_sample;
        end
        if (s2_ready && r_s1_vld) begin
            r_s2_mag  <= mag;
            r_s2_last <= r_s1_last;
        end
        if (s3_ready && r_s2_vld) begin
            r_s3_prod <= 64'(r_s2_mag) * 64'(r_cfg_step);
            r_s3_last <= r_s2_last;
        end
        if (s3_adv && (nb != '0)) begin
            r_ob_word <= aligned;
            r_ob_last <= r_s3_last;
        end else if (out_acc) begin
            r_ob_word <= r_ob_word << 8;
        end
    end

    // a finished stream leaves no pending bits behind
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_adv && r_s3_last) |=> (r_pend == 3'd0))
        else $error("pending bits survive end of stream");

    // never queue more bytes than one code can produce
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ob_cnt) <= MAX_BYTES)
        else $error("output byte count out of range");

    // a stalled byte is not overwritten by the next request
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte)
            && $stable(o_out_last)))
        else $error("stalled output byte changed");

endmodule

### tb/qbp_checker.sv
// ----------------------------------------------------------------------------
// qbp_checker: stream predictor and byte comparator for the bit packer
// Tracks register writes and accepted samples, builds the expected packed
// byte stream and compares every accepted output byte against it.
// ----------------------------------------------------------------------------
module qbp_checker
    import qbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_sample,
    input  logic               i_last_sample,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_out_byte,
    input  logic               i_out_last,
    output int                 o_fail_count,
    output int                 o_owed_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_stream_byte;

    t_stream_byte owed_bytes[$];

    logic signed [31:0] min_value_q;
    logic        [31:0] step_recip_q;
    logic        [5:0]  bits_q;
    logic        [7:0]  bit_acc;
    int                 bit_cnt;
    int                 fail_cnt = 0;
    int                 owed_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_owed_count = owed_cnt;

    function automatic logic [32:0] quantize_index(logic signed [31:0] sample_val,
                                                   int width);
        logic signed [32:0] diff;
        logic        [64:0] prod;
        logic        [32:0] idx;
        logic        [32:0] top_code;
        diff = $signed({sample_val[31], sample_val}) - $signed({min_value_q[31], min_value_q});
        if (diff[32] || diff == '0) begin
            idx = '0;
        end else begin
            prod = {33'd0, diff[31:0]} * {33'd0, step_recip_q};
            prod = prod + 65'h8000_0000;
            idx  = prod[64:32];
        end
        top_code = (33'd1 << width) - 33'd1;
        if (idx > top_code) begin
            idx = top_code;
        end
        return idx;
    endfunction

    task automatic pack_sample(logic signed [31:0] sample_val, logic is_last);
        int          width;
        int          emitted;
        logic [32:0] code;
        width   = int'(bits_q);
        emitted = 0;
        if (width == 0) begin
            width = 1;
        end
        if (width > MAX_CODE_BITS) begin
            width = MAX_CODE_BITS;
        end
        code = quantize_index(sample_val, width);
        for (int b = width - 1; b >= 0; b--) begin
            bit_acc = {bit_acc[6:0], code[b]};
            bit_cnt++;
            if (bit_cnt == 8) begin
                owed_bytes.push_back('{data: bit_acc, is_last: 1'b0});
                emitted++;
                bit_acc = '0;
                bit_cnt = 0;
            end
        end
        if (is_last) begin
            // pad a partial byte on the right, else flag the byte just completed
            if (bit_cnt > 0) begin
                owed_bytes.push_back('{data: bit_acc << (8 - bit_cnt), is_last: 1'b1});
            end else if (emitted > 0) begin
                owed_bytes[owed_bytes.size() - 1].is_last = 1'b1;
            end
            bit_acc = '0;
            bit_cnt = 0;
        end
    endtask

    task automatic compare_byte();
        t_stream_byte want;
        if (owed_bytes.size() == 0) begin
            $display("%0t: expected no byte, got 8'h%02h last %0b",
                     $time, i_out_byte, i_out_last);
            fail_cnt++;
        end else begin
            want = owed_bytes.pop_front();
            if (i_out_byte !== want.data) begin
                $display("%0t: out_byte expected 8'h%02h, got 8'h%02h",
                         $time, want.data, i_out_byte);
                fail_cnt++;
            end
            if (i_out_last !== want.is_last) begin
                $display("%0t: out_last expected %0b, got %0b",
                         $time, want.is_last, i_out_last);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_value_q  = MIN_VALUE_RESET;
            step_recip_q = STEP_RECIP_RESET;
            bits_q       = BITS_RESET;
            bit_acc      = '0;
            bit_cnt      = 0;
            owed_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_VALUE:      min_value_q  = i_cfg_data;
                    CFG_STEP_RECIP:     step_recip_q = i_cfg_data;
                    CFG_BITS_PER_VALUE: bits_q       = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pack_sample(i_sample, i_last_sample);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_byte();
            end
        end
        owed_cnt = owed_bytes.size();
    end

endmodule

### tb/tb_quantize_bit_packer.sv
// ----------------------------------------------------------------------------
// tb_quantize_bit_packer: stimulus and verdict for the quantize bit packer
// Drives directed corner samples and random sample streams under several
// register settings and idle patterns; a checker alongside predicts bytes.
// ----------------------------------------------------------------------------
module tb_quantize_bit_packer;
    import qbp_pkg::*;

    // index with no register behind it; writes there must be ignored
    localparam logic [1:0] CFG_NO_REG     = 2'd3;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         HOLDOFF_CYCLES = 300;
    localparam int         SEGMENT_ITEMS  = 49;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_index   = '0;
    logic [31:0]        i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic signed [31:0] i_sample      = '0;
    logic               i_last_sample = 1'b0;
    logic               i_out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [7:0]         o_out_byte;
    logic               o_out_last;

    int                 fail_count;
    int                 owed_count;
    int                 cycle_count   = 0;
    int                 tx_idle_pct   = 13;
    int                 rx_stall_pct  = 83;
    int                 holdoff_left  = 0;
    bit                 hold_request  = 1'b0;
    bit                 hold_served   = 1'b0;
    logic signed [31:0] cur_min       = MIN_VALUE_RESET;

    quantize_bit_packer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last)
    );

    qbp_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_byte    (o_out_byte),
        .i_out_last    (o_out_last),
        .o_fail_count  (fail_count),
        .o_owed_count  (owed_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (hold_request && !hold_served) begin
            hold_served  = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    task automatic write_regs(logic signed [31:0] min_val, logic [31:0] recip,
                              logic [5:0] width);
        write_reg(CFG_MIN_VALUE, min_val);
        write_reg(CFG_STEP_RECIP, recip);
        write_reg(CFG_BITS_PER_VALUE, {26'd0, width});
        i_cfg_we <= 1'b0;
        cur_min = min_val;
    endtask

    task automatic send_sample(logic signed [31:0] sample_val, logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample      <= sample_val;
        i_last_sample <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every owed byte, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (owed_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] random_sample();
        logic signed [31:0] val;
        case ($urandom_range(7))
            1:       val = cur_min + $urandom_range(3);
            2, 3, 4: val = cur_min + ($urandom >> $urandom_range(31));
            5:       val = cur_min - ($urandom >> $urandom_range(31));
            6:       val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: val = $urandom;
        endcase
        return val;
    endfunction

    task automatic run_segment(int n_items);
        logic signed [31:0] min_val;
        logic        [31:0] recip;
        logic        [5:0]  width;
        min_val = $urandom;
        if ($urandom_range(1)) begin
            min_val = min_val >>> $urandom_range(31);
        end
        recip = $urandom >> $urandom_range(31);
        width = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
        write_regs(min_val, recip, width);
        repeat (n_items) begin
            send_sample(random_sample(), $urandom_range(11) == 0);
        end
        settle();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 8-bit codes, unit step, zero offset
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh0000_8000, 1'b0);
        send_sample(32'sh0000_7FFF, 1'b0);
        send_sample(32'sh0005_0000, 1'b1);
        settle();

        // 3-bit codes ending mid-byte, so the last byte gets padded
        write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
        write_regs(32'shFFFF_0000, 32'h0002_0000, 6'd3);
        send_sample(32'shFFFF_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0002_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_4000, 1'b1);
        settle();

        // zero width acts as one bit; most negative offset, largest step reciprocal
        write_regs(32'sh8000_0000, 32'hFFFF_FFFF, 6'd0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0001, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        settle();

        // width above the limit clamps to 32; stream ends on a byte boundary
        write_regs(32'sh8000_0000, 32'hFFFF_FFFF, 6'd40);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh1234_5678, 1'b1);
        settle();

        write_regs(32'sh7FFF_FFFF, 32'h0000_0000, 6'd63);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
        settle();

        repeat (2) run_segment(SEGMENT_ITEMS);

        tx_idle_pct  = 83;
        rx_stall_pct = 13;
        repeat (2) run_segment(SEGMENT_ITEMS);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        repeat (2) run_segment(SEGMENT_ITEMS);

        if (fail_count == 0 && owed_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
